@@ sv/kwl_pkg.sv @@
// shared types and constants for the k-weighted loudness window engine
// used by kwl_lane and k_weighted_loudness_windows_top
package kwl_pkg;

  localparam int COEF_BITS      = 32;
  localparam int DLY_BITS       = 40;
  localparam int DLY_FRAC       = 8;
  localparam int HOP_BITS       = 49;
  localparam int MOM_BITS       = 51;
  localparam int SHORT_BITS     = 54;
  localparam int COUNT_BITS     = 32;
  localparam int HOPF_BITS      = 17;
  localparam int CFG_IDX_BITS   = 3;

  localparam int DEF_MOMENTARY_HOPS = 4;
  localparam int DEF_SHORT_HOPS     = 30;
  localparam int DEF_RING_DEPTH     = 32;
  localparam int DEF_SAMPLE_BITS    = 24;
  localparam int DEF_COEF_FRAC_BITS = 28;

  localparam logic [HOPF_BITS-1:0] HOP_FRAMES_RESET = HOPF_BITS'(4800);

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_HEAD_B0,
    REG_HEAD_B1,
    REG_HEAD_B2,
    REG_HEAD_A1,
    REG_HEAD_A2,
    REG_HP_A1,
    REG_HP_A2,
    REG_HOP_FRAMES
  } reg_idx_t;

  typedef struct packed {
    logic signed [COEF_BITS-1:0] b0;
    logic signed [COEF_BITS-1:0] b1;
    logic signed [COEF_BITS-1:0] b2;
    logic signed [COEF_BITS-1:0] a1;
    logic signed [COEF_BITS-1:0] a2;
    logic signed [COEF_BITS-1:0] hp_a1;
    logic signed [COEF_BITS-1:0] hp_a2;
  } coef_t;

endpackage

@@ sv/k_weighted_loudness_windows_top.sv @@
// k-weighted loudness window engine: two filter lanes, hop accumulator,
// hop ring and window sums; depends on kwl_pkg and kwl_lane
//
// usage: one stereo frame is taken per input item (in_valid high, in_stall
// low). both channels run in parallel lanes, each doing its ten biquad
// products one per cycle on its own multiplier, then squaring the output.
// a frame that does not close a hop passes the lanes and S_ACC before the
// next frame can be taken; a closing frame also passes S_WR, S_RM, S_RS
// and S_OUT, since the window update reads two old hop sums from the ring
// memory one per cycle. in_stall is high while a frame is in work.
// a closing frame puts one item in the output register, where it stays
// until taken while out_stall is low; a new frame is accepted meanwhile,
// and if the next hop closes before the item is taken, the block waits.
// reset loads the default hop length and clears the filters, hop state
// and windows; restart on an item clears them before that frame, keeping
// coefficients. the ring needs no clearing: a fill count masks old entries.
// configuration is written through cfg_write, cfg_index and cfg_data.
module k_weighted_loudness_windows_top #(
  parameter int MOMENTARY_HOPS = kwl_pkg::DEF_MOMENTARY_HOPS,
  parameter int SHORT_HOPS     = kwl_pkg::DEF_SHORT_HOPS,
  parameter int RING_DEPTH     = kwl_pkg::DEF_RING_DEPTH,
  parameter int SAMPLE_BITS    = kwl_pkg::DEF_SAMPLE_BITS,
  parameter int COEF_FRAC_BITS = kwl_pkg::DEF_COEF_FRAC_BITS
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_write,
  input  logic [kwl_pkg::CFG_IDX_BITS-1:0]      cfg_index,
  input  logic [kwl_pkg::COEF_BITS-1:0]         cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [SAMPLE_BITS-1:0]         left_sample,
  input  logic signed [SAMPLE_BITS-1:0]         right_sample,
  input  logic                                  restart,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [kwl_pkg::MOM_BITS-1:0]          momentary_energy,
  output logic                                  momentary_valid,
  output logic [kwl_pkg::SHORT_BITS-1:0]        short_term_energy,
  output logic                                  short_term_valid,
  output logic [kwl_pkg::COUNT_BITS-1:0]        hop_count
);

  localparam int HB    = kwl_pkg::HOP_BITS;
  localparam int E_W   = 2 * SAMPLE_BITS;
  localparam int ES_W  = E_W + 1;
  localparam int AW    = ((HB > ES_W) ? HB : ES_W) + 1;
  localparam int PW    = $clog2(RING_DEPTH);
  localparam int FW    = $clog2(SHORT_HOPS + 1);
  localparam int MRW   = HB + $clog2(MOMENTARY_HOPS + 1);
  localparam int SRW   = HB + $clog2(SHORT_HOPS + 1);
  localparam int FLW   = kwl_pkg::HOPF_BITS;
  localparam logic [AW-1:0]  HOP_MAX  = AW'((65'd1 << HB) - 65'd1);
  localparam logic [63:0]    MOM_MAX  = 64'((65'd1 << kwl_pkg::MOM_BITS) - 65'd1);
  localparam logic [63:0]    ST_MAX   = 64'((65'd1 << kwl_pkg::SHORT_BITS) - 65'd1);
  localparam logic [PW:0]    DEPTH_V  = (PW+1)'(RING_DEPTH);
  localparam logic [PW:0]    MOM_OFF  = (PW+1)'(MOMENTARY_HOPS);
  localparam logic [PW:0]    ST_OFF   = (PW+1)'(SHORT_HOPS);
  localparam logic [FW-1:0]  FILL_MOM = FW'(MOMENTARY_HOPS);
  localparam logic [FW-1:0]  FILL_ST  = FW'(SHORT_HOPS);

  typedef enum logic [2:0] {
    S_IDLE, S_LANE, S_ACC, S_WR, S_RM, S_RS, S_OUT
  } state_t;

  state_t                      state;
  kwl_pkg::coef_t              coef;
  logic [FLW-1:0]              hop_frames;
  logic [FLW-1:0]              frames_left;
  logic [HB-1:0]               hop_acc;
  logic [HB-1:0]               hop_val;
  logic [PW-1:0]               ptr;
  logic [FW-1:0]               filled;
  logic [MRW-1:0]              mom_run;
  logic [SRW-1:0]              st_run;
  logic [kwl_pkg::COUNT_BITS-1:0] completions;
  logic [HB-1:0]               ring [RING_DEPTH];
  logic [HB-1:0]               rd_data;

  logic                        accept;
  logic                        lane_done_l, lane_done_r;
  logic [E_W-1:0]              energy_l, energy_r;
  logic [FLW-1:0]              reload;
  logic [ES_W-1:0]             frame_e;
  logic [AW-1:0]               acc_sum;
  logic [HB-1:0]               acc_next;
  logic [PW-1:0]               rd_addr;
  logic [PW:0]                 back_off;
  logic [PW:0]                 ptr_w;
  logic [MRW:0]                mom_next;
  logic [SRW:0]                st_next;
  logic [63:0]                 mom_ext, st_ext;
  logic                        mv, sv;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state != S_IDLE);
  assign reload   = (hop_frames == '0) ? FLW'(1) : hop_frames;
  assign frame_e  = ES_W'(energy_l) + ES_W'(energy_r);
  assign acc_sum  = AW'(hop_acc) + AW'(frame_e);
  assign acc_next = (acc_sum > HOP_MAX) ? HB'(HOP_MAX) : HB'(acc_sum);

  assign ptr_w    = (PW+1)'(ptr);
  assign back_off = (state == S_WR) ? MOM_OFF : ST_OFF;
  assign rd_addr  = PW'((ptr_w >= back_off) ? (ptr_w - back_off)
                                            : (ptr_w + DEPTH_V - back_off));

  assign mom_next = (MRW+1)'(mom_run) + (MRW+1)'(hop_val)
                  - ((filled >= FILL_MOM) ? (MRW+1)'(rd_data) : '0);
  assign st_next  = (SRW+1)'(st_run) + (SRW+1)'(hop_val)
                  - ((filled >= FILL_ST) ? (SRW+1)'(rd_data) : '0);
  assign mom_ext  = 64'(mom_run);
  assign st_ext   = 64'(st_run);
  assign mv       = (filled >= FILL_MOM);
  assign sv       = (filled >= FILL_ST);

  kwl_lane #(
    .SAMPLE_BITS    (SAMPLE_BITS),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_lane_l (
    .clk     (clk),
    .rst     (rst),
    .start   (accept),
    .restart (restart),
    .sample  (left_sample),
    .coef    (coef),
    .done    (lane_done_l),
    .energy  (energy_l)
  );

  kwl_lane #(
    .SAMPLE_BITS    (SAMPLE_BITS),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_lane_r (
    .clk     (clk),
    .rst     (rst),
    .start   (accept),
    .restart (restart),
    .sample  (right_sample),
    .coef    (coef),
    .done    (lane_done_r),
    .energy  (energy_r)
  );

  always_ff @(posedge clk) begin
    rd_data <= ring[rd_addr];
    if (state == S_WR) begin
      ring[ptr] <= hop_val;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      coef       <= '0;
      hop_frames <= kwl_pkg::HOP_FRAMES_RESET;
    end else if (cfg_write) begin
      unique case (kwl_pkg::reg_idx_t'(cfg_index))
        kwl_pkg::REG_HEAD_B0:    coef.b0    <= cfg_data;
        kwl_pkg::REG_HEAD_B1:    coef.b1    <= cfg_data;
        kwl_pkg::REG_HEAD_B2:    coef.b2    <= cfg_data;
        kwl_pkg::REG_HEAD_A1:    coef.a1    <= cfg_data;
        kwl_pkg::REG_HEAD_A2:    coef.a2    <= cfg_data;
        kwl_pkg::REG_HP_A1:      coef.hp_a1 <= cfg_data;
        kwl_pkg::REG_HP_A2:      coef.hp_a2 <= cfg_data;
        kwl_pkg::REG_HOP_FRAMES: hop_frames <= cfg_data[FLW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      frames_left <= kwl_pkg::HOP_FRAMES_RESET;
      hop_acc     <= '0;
      ptr         <= '0;
      filled      <= '0;
      mom_run     <= '0;
      st_run      <= '0;
      completions <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (out_valid && !out_stall && state != S_OUT) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_LANE;
            if (restart) begin
              frames_left <= reload;
              hop_acc     <= '0;
              ptr         <= '0;
              filled      <= '0;
              mom_run     <= '0;
              st_run      <= '0;
              completions <= '0;
            end
          end
        end
        S_LANE: begin
          if (lane_done_l && lane_done_r) begin
            state <= S_ACC;
          end
        end
        S_ACC: begin
          if (frames_left > FLW'(1)) begin
            frames_left <= frames_left - FLW'(1);
            hop_acc     <= acc_next;
            state       <= S_IDLE;
          end else begin
            hop_val     <= acc_next;
            hop_acc     <= '0;
            frames_left <= reload;
            state       <= S_WR;
          end
        end
        S_WR: begin
          state <= S_RM;
        end
        S_RM: begin
          mom_run <= MRW'(mom_next);
          state   <= S_RS;
        end
        S_RS: begin
          st_run <= SRW'(st_next);
          ptr    <= (ptr == PW'(RING_DEPTH - 1)) ? '0 : ptr + PW'(1);
          if (filled < FILL_ST) begin
            filled <= filled + FW'(1);
          end
          if (completions != '1) begin
            completions <= completions + 1'b1;
          end
          state <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid || !out_stall) begin
            out_valid         <= 1'b1;
            momentary_valid   <= mv;
            short_term_valid  <= sv;
            momentary_energy  <= !mv ? '0 :
                                 ((mom_ext > MOM_MAX) ? '1 : mom_ext[kwl_pkg::MOM_BITS-1:0]);
            short_term_energy <= !sv ? '0 :
                                 ((st_ext > ST_MAX) ? '1 : st_ext[kwl_pkg::SHORT_BITS-1:0]);
            hop_count         <= completions;
            state             <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ sv/kwl_lane.sv @@
// one channel lane: head shelf and high-pass biquads on a shared multiplier,
// then the squared output; depends on kwl_pkg
module kwl_lane #(
  parameter int SAMPLE_BITS    = kwl_pkg::DEF_SAMPLE_BITS,
  parameter int COEF_FRAC_BITS = kwl_pkg::DEF_COEF_FRAC_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic                          restart,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  input  kwl_pkg::coef_t                coef,
  output logic                          done,
  output logic [2*SAMPLE_BITS-1:0]      energy
);

  localparam int CB     = kwl_pkg::COEF_BITS;
  localparam int DB     = kwl_pkg::DLY_BITS;
  localparam int DF     = kwl_pkg::DLY_FRAC;
  localparam int PROD_W = CB + SAMPLE_BITS;
  localparam int SHIFT  = COEF_FRAC_BITS - DF;
  localparam int FL_W   = PROD_W - SHIFT;
  localparam int ACC_W  = ((FL_W > DB) ? FL_W : DB) + 2;
  localparam logic [3:0] LAST_STEP = 4'd12;
  localparam logic [3:0] HP_STEP   = 4'd6;

  localparam logic signed [CB-1:0] ONE  = CB'(64'sd1 <<< COEF_FRAC_BITS);
  localparam logic signed [CB-1:0] MTWO = CB'(-(64'sd2 <<< COEF_FRAC_BITS));
  localparam logic signed [ACC_W-1:0] ROUND = ACC_W'(64'sd1 <<< (DF - 1));
  localparam logic signed [ACC_W-1:0] YMAX = ACC_W'((64'sd1 <<< (SAMPLE_BITS-1)) - 64'sd1);
  localparam logic signed [ACC_W-1:0] YMIN = ACC_W'(-(64'sd1 <<< (SAMPLE_BITS-1)));
  localparam logic signed [ACC_W-1:0] DMAX = ACC_W'((64'sd1 <<< (DB-1)) - 64'sd1);
  localparam logic signed [ACC_W-1:0] DMIN = ACC_W'(-(64'sd1 <<< (DB-1)));

  logic                          active;
  logic [3:0]                    step;
  logic signed [SAMPLE_BITS-1:0] x;
  logic signed [SAMPLE_BITS-1:0] y;
  logic signed [PROD_W-1:0]      prod;
  logic signed [ACC_W-1:0]       n1;
  logic signed [ACC_W-1:0]       n2;
  logic signed [DB-1:0]          hd0, hd1, pd0, pd1;

  logic                          st;
  logic [3:0]                    ph;
  logic signed [CB-1:0]          c_sel;
  logic signed [SAMPLE_BITS-1:0] opnd;
  logic signed [PROD_W-1:0]      prod_next;
  logic signed [ACC_W-1:0]       fl;
  logic signed [ACC_W-1:0]       d0_ext, d1_ext;
  logic signed [ACC_W-1:0]       y_full;
  logic signed [ACC_W-1:0]       y_sat;
  logic signed [ACC_W-1:0]       n2_fin;
  logic signed [DB-1:0]          n1_sat, n2_sat;
  logic signed [2*SAMPLE_BITS-1:0] sq;

  always_comb begin
    st = (step >= HP_STEP);
    ph = st ? (step - HP_STEP) : step;
    case (ph)
      4'd0:    c_sel = st ? ONE : coef.b0;
      4'd1:    c_sel = st ? MTWO : coef.b1;
      4'd2:    c_sel = st ? coef.hp_a1 : coef.a1;
      4'd3:    c_sel = st ? ONE : coef.b2;
      4'd4:    c_sel = st ? coef.hp_a2 : coef.a2;
      default: c_sel = '0;
    endcase
    opnd = (ph == 4'd2 || ph == 4'd4) ? y : x;
  end

  assign prod_next = c_sel * opnd;
  assign fl        = ACC_W'(prod >>> SHIFT);
  assign d0_ext    = ACC_W'(st ? pd0 : hd0);
  assign d1_ext    = ACC_W'(st ? pd1 : hd1);
  assign y_full    = (fl + d0_ext + ROUND) >>> DF;
  assign y_sat     = (y_full > YMAX) ? YMAX : ((y_full < YMIN) ? YMIN : y_full);
  assign n2_fin    = n2 - fl;
  assign n1_sat    = DB'((n1 > DMAX) ? DMAX : ((n1 < DMIN) ? DMIN : n1));
  assign n2_sat    = DB'((n2_fin > DMAX) ? DMAX : ((n2_fin < DMIN) ? DMIN : n2_fin));
  assign sq        = y * y;

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      step   <= '0;
      done   <= 1'b0;
      hd0    <= '0;
      hd1    <= '0;
      pd0    <= '0;
      pd1    <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        active <= 1'b1;
        step   <= '0;
        x      <= sample;
        if (restart) begin
          hd0 <= '0;
          hd1 <= '0;
          pd0 <= '0;
          pd1 <= '0;
        end
      end else if (active) begin
        prod <= prod_next;
        step <= step + 4'd1;
        case (ph)
          4'd1: y  <= SAMPLE_BITS'(y_sat);
          4'd2: n1 <= fl + d1_ext;
          4'd3: n1 <= n1 - fl;
          4'd4: n2 <= fl;
          4'd5: begin
            x <= y;
            if (st) begin
              pd0 <= n1_sat;
              pd1 <= n2_sat;
            end else begin
              hd0 <= n1_sat;
              hd1 <= n2_sat;
            end
          end
          default: ;
        endcase
        if (step == LAST_STEP) begin
          energy <= sq;
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

endmodule

@@ dv/k_weighted_loudness_windows_top_tb.sv @@
// testbench for k_weighted_loudness_windows_top: random and directed stereo frames,
// a scoreboard class predicts hop windows; depends on kwl_pkg and the block rtl
module k_weighted_loudness_windows_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SBITS = kwl_pkg::DEF_SAMPLE_BITS;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int LONG_HOLD = 400;

  typedef struct {
    logic [kwl_pkg::MOM_BITS-1:0]   mom;
    logic                           mom_ok;
    logic [kwl_pkg::SHORT_BITS-1:0] st;
    logic                           st_ok;
    logic [kwl_pkg::COUNT_BITS-1:0] hops;
  } hop_window_t;

  class loudness_scoreboard;
    longint coef [7];
    int unsigned hop_len;
    longint head_d [4];
    longint hp_d [4];
    longint unsigned hop_acc;
    int unsigned frames_left;
    longint unsigned ring [kwl_pkg::DEF_RING_DEPTH];
    int ring_ptr;
    int hops_filled;
    longint unsigned completions;
    hop_window_t pending [$];
    int errors;

    function new();
      foreach (coef[i]) coef[i] = 0;
      hop_len = int'(kwl_pkg::HOP_FRAMES_RESET);
      errors = 0;
      clear_state();
    endfunction

    function void clear_state();
      foreach (head_d[i]) head_d[i] = 0;
      foreach (hp_d[i]) hp_d[i] = 0;
      foreach (ring[i]) ring[i] = 0;
      hop_acc = 0;
      frames_left = (hop_len == 0) ? 1 : hop_len;
      ring_ptr = 0;
      hops_filled = 0;
      completions = 0;
    endfunction

    function void write_reg(kwl_pkg::reg_idx_t idx, logic [kwl_pkg::COEF_BITS-1:0] v);
      if (idx == kwl_pkg::REG_HOP_FRAMES) hop_len = int'(v[kwl_pkg::HOPF_BITS-1:0]);
      else coef[int'(idx)] = longint'(signed'(v));
    endfunction

    function longint clamp(longint v, int bits);
      longint hi, lo;
      hi = (longint'(1) <<< (bits - 1)) - 1;
      lo = -hi - 1;
      return v > hi ? hi : (v < lo ? lo : v);
    endfunction

    function longint scale(longint c, longint x);
      return (c * x) >>> (kwl_pkg::DEF_COEF_FRAC_BITS - kwl_pkg::DLY_FRAC);
    endfunction

    function longint biquad(longint x, longint b0, longint b1, longint b2,
                            longint a1, longint a2, inout longint d0, inout longint d1);
      longint y, n1, n2;
      y = clamp((scale(b0, x) + d0 + 128) >>> kwl_pkg::DLY_FRAC, SBITS);
      n1 = scale(b1, x) - scale(a1, y) + d1;
      n2 = scale(b2, x) - scale(a2, y);
      d0 = clamp(n1, kwl_pkg::DLY_BITS);
      d1 = clamp(n2, kwl_pkg::DLY_BITS);
      return y;
    endfunction

    function longint unsigned channel_energy(longint x, int ch);
      longint one, h, y;
      one = longint'(1) <<< kwl_pkg::DEF_COEF_FRAC_BITS;
      h = biquad(x, coef[0], coef[1], coef[2], coef[3], coef[4],
                 head_d[2*ch], head_d[2*ch+1]);
      y = biquad(h, one, -2 * one, one, coef[5], coef[6], hp_d[2*ch], hp_d[2*ch+1]);
      return longint'(y * y);
    endfunction

    function longint unsigned window_sum(int count);
      longint unsigned s;
      s = 0;
      for (int k = 0; k < count; k++)
        s += ring[(ring_ptr + 2 * kwl_pkg::DEF_RING_DEPTH - 1 - k) % kwl_pkg::DEF_RING_DEPTH];
      return s;
    endfunction

    function void note_frame(logic signed [SBITS-1:0] l, logic signed [SBITS-1:0] r,
                             logic rs);
      hop_window_t w;
      longint unsigned mom, st;
      if (rs) clear_state();
      hop_acc += channel_energy(longint'(l), 0) + channel_energy(longint'(r), 1);
      if (hop_acc > (64'd1 << kwl_pkg::HOP_BITS) - 1)
        hop_acc = (64'd1 << kwl_pkg::HOP_BITS) - 1;
      if (frames_left > 1) begin
        frames_left--;
        return;
      end
      ring[ring_ptr] = hop_acc;
      ring_ptr = (ring_ptr + 1) % kwl_pkg::DEF_RING_DEPTH;
      hop_acc = 0;
      frames_left = (hop_len == 0) ? 1 : hop_len;
      if (hops_filled < kwl_pkg::DEF_SHORT_HOPS) hops_filled++;
      if (completions != 64'hFFFF_FFFF) completions++;
      mom = window_sum(kwl_pkg::DEF_MOMENTARY_HOPS);
      if (mom > (64'd1 << kwl_pkg::MOM_BITS) - 1) mom = (64'd1 << kwl_pkg::MOM_BITS) - 1;
      st = window_sum(kwl_pkg::DEF_SHORT_HOPS);
      if (st > (64'd1 << kwl_pkg::SHORT_BITS) - 1) st = (64'd1 << kwl_pkg::SHORT_BITS) - 1;
      w.mom_ok = hops_filled >= kwl_pkg::DEF_MOMENTARY_HOPS;
      w.st_ok = hops_filled >= kwl_pkg::DEF_SHORT_HOPS;
      w.mom = w.mom_ok ? mom[kwl_pkg::MOM_BITS-1:0] : '0;
      w.st = w.st_ok ? st[kwl_pkg::SHORT_BITS-1:0] : '0;
      w.hops = completions[kwl_pkg::COUNT_BITS-1:0];
      pending.push_back(w);
    endfunction

    function void check_result(hop_window_t got);
      hop_window_t exp_w;
      if (pending.size() == 0) begin
        $error("result item with no expectation, hop_count %0d", got.hops);
        errors++;
        return;
      end
      exp_w = pending.pop_front();
      if (got.mom !== exp_w.mom) begin
        $error("momentary_energy expected %0d got %0d", exp_w.mom, got.mom);
        errors++;
      end
      if (got.mom_ok !== exp_w.mom_ok) begin
        $error("momentary_valid expected %0d got %0d", exp_w.mom_ok, got.mom_ok);
        errors++;
      end
      if (got.st !== exp_w.st) begin
        $error("short_term_energy expected %0d got %0d", exp_w.st, got.st);
        errors++;
      end
      if (got.st_ok !== exp_w.st_ok) begin
        $error("short_term_valid expected %0d got %0d", exp_w.st_ok, got.st_ok);
        errors++;
      end
      if (got.hops !== exp_w.hops) begin
        $error("hop_count expected %0d got %0d", exp_w.hops, got.hops);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic cfg_write;
  logic [kwl_pkg::CFG_IDX_BITS-1:0] cfg_index;
  logic [kwl_pkg::COEF_BITS-1:0] cfg_data;
  logic in_valid;
  logic in_stall;
  logic signed [SBITS-1:0] left_sample;
  logic signed [SBITS-1:0] right_sample;
  logic restart;
  logic out_valid;
  logic out_stall;
  logic [kwl_pkg::MOM_BITS-1:0] momentary_energy;
  logic momentary_valid;
  logic [kwl_pkg::SHORT_BITS-1:0] short_term_energy;
  logic short_term_valid;
  logic [kwl_pkg::COUNT_BITS-1:0] hop_count;

  loudness_scoreboard sb = new();
  int results_seen = 0;
  int idle_cycles = 0;
  bit bursty = 0;

  k_weighted_loudness_windows_top dut (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    hop_window_t w;
    if (!rst && in_valid && !in_stall) sb.note_frame(left_sample, right_sample, restart);
    if (!rst && out_valid && !out_stall) begin
      w.mom = momentary_energy;
      w.mom_ok = momentary_valid;
      w.st = short_term_energy;
      w.st_ok = short_term_valid;
      w.hops = hop_count;
      sb.check_result(w);
      results_seen++;
    end
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_write)
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // result side: random holds, quiet stretches, one long hold to back up the block
  initial begin
    int w;
    bit long_done;
    long_done = 0;
    out_stall = 1;
    @(negedge rst);
    @(posedge clk);
    forever begin
      if (!long_done && results_seen >= 60) begin
        long_done = 1;
        out_stall <= 1;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        w = ((results_seen / 40) % 3 == 1) ? 0 : $urandom_range(0, 16);
        if (w > 0) begin
          out_stall <= 1;
          repeat (w) @(posedge clk);
        end
      end
      out_stall <= 0;
      do @(posedge clk); while (!out_valid);
    end
  end

  task automatic send_frame(logic signed [SBITS-1:0] l, logic signed [SBITS-1:0] r,
                            logic rs);
    int gap;
    gap = bursty ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    left_sample <= l;
    right_sample <= r;
    restart <= rs;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic write_reg(kwl_pkg::reg_idx_t idx, logic [kwl_pkg::COEF_BITS-1:0] v);
    cfg_write <= 1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    sb.write_reg(idx, v);
  endtask

  // block must be quiet before registers change
  task automatic settle();
    in_valid <= 0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic load_coefs(int mode, int hop, logic [kwl_pkg::COEF_BITS-1:0] hop_upper);
    logic [kwl_pkg::COEF_BITS-1:0] k_set [7];
    k_set = '{32'sd412081942, -32'sd722546696, 32'sd321691121, -32'sd453832898,
              32'sd196623810, -32'sd534199295, 32'sd265770496};
    for (int i = 0; i < 7; i++) begin
      case (mode)
        0: write_reg(kwl_pkg::reg_idx_t'(i), k_set[i]);
        1: write_reg(kwl_pkg::reg_idx_t'(i), 32'h7FFF_FFFF);
        2: write_reg(kwl_pkg::reg_idx_t'(i), 32'h8000_0000);
        3: write_reg(kwl_pkg::reg_idx_t'(i), 32'h0);
        default: write_reg(kwl_pkg::reg_idx_t'(i), $urandom());
      endcase
    end
    write_reg(kwl_pkg::REG_HOP_FRAMES,
              {hop_upper[kwl_pkg::COEF_BITS-1:kwl_pkg::HOPF_BITS],
               kwl_pkg::HOPF_BITS'(hop)});
    cfg_write <= 0;
  endtask

  function automatic logic signed [SBITS-1:0] draw_sample();
    case ($urandom_range(0, 7))
      0: return {1'b0, {(SBITS-1){1'b1}}};
      1: return {1'b1, {(SBITS-1){1'b0}}};
      2: return SBITS'($signed($urandom_range(0, 2000)) - 1000);
      3: return '0;
      default: return SBITS'($urandom());
    endcase
  endfunction

  initial begin
    logic signed [SBITS-1:0] smax, smin;
    int hop, mode, count;
    smax = {1'b0, {(SBITS-1){1'b1}}};
    smin = {1'b1, {(SBITS-1){1'b0}}};
    rst = 1;
    cfg_write = 0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 0;
    left_sample = '0;
    right_sample = '0;
    restart = 0;
    repeat (8) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: k-weighting, zero hop length acts as one, extremes, mono, restart
    load_coefs(0, 0, '0);
    send_frame(smax, smax, 0);
    send_frame(smin, smin, 0);
    send_frame(smax, smin, 0);
    send_frame(smin, smax, 0);
    send_frame(smax, '0, 0);
    send_frame(smin, '0, 0);
    send_frame('0, '0, 1);
    send_frame(smax, smax, 0);
    send_frame(smax, smax, 0);
    send_frame(smax, smax, 0);
    send_frame(smax, smax, 1);
    for (int i = 0; i < 5; i++) send_frame(smin, smax, 0);
    settle();
    load_coefs(1, 3, 32'hFFFF_FFFF);
    for (int i = 0; i < 6; i++) send_frame(smax, smin, 0);
    settle();
    load_coefs(2, 2, '0);
    for (int i = 0; i < 4; i++) send_frame(smin, smin, 0);
    settle();

    // longest hop: frames go in, none closes
    load_coefs(3, (1 << kwl_pkg::HOPF_BITS) - 1, '0);
    for (int i = 0; i < 30; i++) send_frame(draw_sample(), draw_sample(), 0);
    settle();

    for (int p = 0; p < 9; p++) begin
      mode = (p < 5) ? p : 0;
      if (p == 7) mode = 4;
      hop = $urandom_range(0, 6);
      load_coefs(mode, hop, $urandom());
      bursty = (p % 3 == 2);
      count = 175;
      for (int i = 0; i < count; i++)
        send_frame(draw_sample(), ($urandom_range(0, 5) == 0) ? '0 : draw_sample(),
                   ($urandom_range(0, 79) == 0) || (i == 0 && p % 2 == 1));
      settle();
    end
    repeat (60) @(posedge clk);
    if (sb.pending.size() != 0) sb.errors++;
    if (sb.errors == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end
endmodule
